### sv/elc_pkg.sv
// ----------------------------------------------------------------------------
// elc_pkg
// Types, opcodes and status codes shared by the extended word machine.
// ----------------------------------------------------------------------------
package elc_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_REG   = 2'd2,
    KIND_EXEC  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_HALT    = 3'd1,
    ST_PCERR   = 3'd2,
    ST_ADDRERR = 3'd3,
    ST_ILLEGAL = 3'd4
  } mstat_t;

  localparam logic [9:0] OP_ADD   = 10'd0;
  localparam logic [9:0] OP_NAND  = 10'd1;
  localparam logic [9:0] OP_LW    = 10'd2;
  localparam logic [9:0] OP_SW    = 10'd3;
  localparam logic [9:0] OP_BEQ   = 10'd4;
  localparam logic [9:0] OP_JALR  = 10'd5;
  localparam logic [9:0] OP_HALT  = 10'd6;
  localparam logic [9:0] OP_MUL   = 10'd7;
  localparam logic [9:0] OP_XADD  = 10'd8;
  localparam logic [9:0] OP_SUB   = 10'd9;
  localparam logic [9:0] OP_XIMUL = 10'd10;
  localparam logic [9:0] OP_XOR   = 10'd11;
  localparam logic [9:0] OP_SHL   = 10'd12;
  localparam logic [9:0] OP_SLT   = 10'd13;
  localparam logic [9:0] OP_BLO   = 10'd14;
  localparam logic [9:0] OP_BGT   = 10'd15;
  localparam logic [9:0] OP_BT    = 10'd16;
  localparam logic [9:0] OP_CMP   = 10'd17;
  localparam logic [9:0] OP_CLC   = 10'd18;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        address;
    logic signed [31:0] data;
    logic [2:0]         reg_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic signed [31:0] program_counter;
    logic               carry_flag;
    logic               sign_flag;
    logic               zero_flag;
    logic [31:0]        executed_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MEMRD, S_FETCH, S_DECODE, S_EXEC, S_LOAD, S_SWAP, S_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_step;
    logic latch_in;
    logic mem_port_rd;
    logic fetch;
    logic decode;
    logic exec;
    logic load_wb;
    logic swap;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic running;
    logic pc_ok;
    logic exec_done;
    logic is_load;
    logic is_swap;
  } sts_t;

endpackage

### sv/elc_ctrl.sv
// ----------------------------------------------------------------------------
// elc_ctrl
// Sequencer: memory clearing pass, then one input word at a time.
// ----------------------------------------------------------------------------
module elc_ctrl
  import elc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  kind_t in_kind,
  output logic  in_ready,
  input  logic  out_valid,
  input  logic  out_ready,
  input  sts_t  sts,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
      S_IDLE: begin
        // A new word may enter once the output register is free or leaving.
        if (in_valid && (!out_valid || out_ready)) begin
          case (in_kind)
            KIND_READ: state_next = S_MEMRD;
            KIND_EXEC: state_next = S_FETCH;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_MEMRD:  state_next = S_OUT;
      S_FETCH:  state_next = (sts.running && sts.pc_ok) ? S_DECODE : S_OUT;
      S_DECODE: state_next = S_EXEC;
      S_EXEC: begin
        if (!sts.exec_done)   state_next = S_OUT;
        else if (sts.is_load) state_next = S_LOAD;
        else if (sts.is_swap) state_next = S_SWAP;
        else                  state_next = S_OUT;
      end
      S_LOAD:  state_next = S_OUT;
      S_SWAP:  state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        in_ready     = !out_valid || out_ready;
        cmd.latch_in = in_valid && in_ready;
      end
      S_MEMRD:  cmd.mem_port_rd = 1'b1;
      S_FETCH:  cmd.fetch = 1'b1;
      S_DECODE: cmd.decode = 1'b1;
      S_EXEC:   cmd.exec = 1'b1;
      S_LOAD:   cmd.load_wb = 1'b1;
      S_SWAP:   cmd.swap = 1'b1;
      S_OUT:    cmd.out_load = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

### sv/elc_dp.sv
// ----------------------------------------------------------------------------
// elc_dp
// Datapath: word memory, register file, pc, flags, status and counter.
// ----------------------------------------------------------------------------
module elc_dp
  import elc_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t res
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [31:0] mem [MEM_WORDS];
  logic [AW:0] clr_addr;

  in_word_t    iw;
  logic [31:0] rf [8];
  logic [31:0] pc;
  logic        cf, sf, zf;
  mstat_t      mst;
  logic [31:0] icount;
  logic [31:0] rv;
  logic [31:0] mem_q;
  logic [31:0] ir;
  logic [31:0] ra_v, rb_v;
  logic        exec_ok;

  // Memory port controls.
  logic          m_we, m_re;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [31:0]   m_wdata;

  wire [9:0]  op  = ir[31:22];
  wire [2:0]  ra  = ir[21:19];
  wire [2:0]  rb  = ir[18:16];
  wire [2:0]  rd  = ir[2:0];
  wire [31:0] off = {{16{ir[15]}}, ir[15:0]};
  wire [32:0] ea  = {ra_v[31], ra_v} + {off[31], off};
  wire        ea_ok = !ea[32] && (ea < 33'(MEM_WORDS));
  wire        pc_ok = !pc[31] && ({1'b0, pc} < 33'(MEM_WORDS));
  wire        in_ok = {16'd0, iw.address} < 32'(MEM_WORDS);

  always_comb begin
    m_we    = 1'b0;
    m_re    = 1'b0;
    m_waddr = clr_addr[AW-1:0];
    m_wdata = '0;
    m_raddr = AW'(iw.address);
    if (cmd.clear_step) begin
      m_we = 1'b1;
    end else if (cmd.out_load && iw.kind == KIND_WRITE && in_ok) begin
      m_we    = 1'b1;
      m_waddr = AW'(iw.address);
      m_wdata = iw.data;
    end else if (cmd.exec && op == OP_SW && ea_ok && mst == ST_RUN) begin
      m_we    = 1'b1;
      m_waddr = ea[AW-1:0];
      m_wdata = rb_v;
    end
    if (cmd.mem_port_rd) m_re = 1'b1;
    if (cmd.fetch) begin
      m_re    = 1'b1;
      m_raddr = pc[AW-1:0];
    end
    if (cmd.exec) begin
      m_re    = 1'b1;
      m_raddr = ea[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) mem[m_waddr] <= m_wdata;
    if (m_re) mem_q <= mem[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_step && clr_addr < (AW+1)'(MEM_WORDS)) clr_addr <= clr_addr + 1'b1;
  end

  assign sts.clear_done = (clr_addr >= (AW+1)'(MEM_WORDS - 1));
  assign sts.running    = (mst == ST_RUN);
  assign sts.pc_ok      = pc_ok;
  assign sts.exec_done  = exec_ok;
  assign sts.is_load    = (op == OP_LW);
  assign sts.is_swap    = (op == OP_XADD) || (op == OP_XIMUL);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) iw <= in_word;
  end

  // Decode stage: latch the instruction and its operands.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      ir   <= mem_q;
      ra_v <= rf[mem_q[21:19]];
      rb_v <= rf[mem_q[18:16]];
    end
  end

  logic [31:0] alu;
  logic        wr_rd;
  logic [31:0] pc_nx;
  logic [4:0]  bt_sh;

  always_comb begin
    alu   = '0;
    wr_rd = 1'b0;
    pc_nx = pc + 32'd1;
    bt_sh = 5'd0;
    if ($signed(rb_v) <= 0) bt_sh = 5'd0;
    else if ($signed(rb_v) >= 31) bt_sh = 5'd31;
    else bt_sh = rb_v[4:0];
    case (op)
      OP_ADD, OP_XADD: begin alu = ra_v + rb_v; wr_rd = 1'b1; end
      OP_NAND:  begin alu = ~(ra_v & rb_v); wr_rd = 1'b1; end
      OP_MUL, OP_XIMUL: begin alu = ra_v * rb_v; wr_rd = 1'b1; end
      OP_SUB:   begin alu = ra_v - rb_v; wr_rd = 1'b1; end
      OP_XOR:   begin alu = ra_v ^ rb_v; wr_rd = 1'b1; end
      OP_SHL:   begin alu = (rb_v >= 32'd32) ? 32'd0 : (ra_v << rb_v[4:0]); wr_rd = 1'b1; end
      OP_SLT:   begin alu = {31'd0, $signed(ra_v) < $signed(rb_v)}; wr_rd = 1'b1; end
      OP_BEQ:   if (ra_v == rb_v) pc_nx = pc + 32'd1 + off;
      OP_BLO:   if (ra_v < rb_v) pc_nx = pc + 32'd1 + off;
      OP_BGT:   if ($signed(ra_v) > $signed(rb_v)) pc_nx = pc + 32'd1 + off;
      // The link is written before the target is read, so a jump through
      // the link register itself lands on the next word.
      OP_JALR:  pc_nx = (ra == 3'd0) ? 32'd0 : ((ra == rb) ? pc + 32'd1 : ra_v);
      default:  alu = '0;
    endcase
  end

  assign exec_ok = (op <= OP_CLC) && !((op == OP_LW || op == OP_SW) && !ea_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) rf[i] <= '0;
      pc     <= '0;
      cf     <= 1'b0;
      sf     <= 1'b0;
      zf     <= 1'b0;
      mst    <= ST_RUN;
      icount <= '0;
    end else begin
      if (cmd.fetch && mst == ST_RUN && !pc_ok) mst <= ST_PCERR;
      if (cmd.exec) begin
        if (op > OP_CLC) mst <= ST_ILLEGAL;
        else if (!exec_ok) mst <= ST_ADDRERR;
        else begin
          if (wr_rd && rd != 3'd0) rf[rd] <= alu;
          if (op == OP_JALR && rb != 3'd0) rf[rb] <= pc + 32'd1;
          if (op == OP_HALT) mst <= ST_HALT;
          if (op == OP_BT) cf <= ra_v[bt_sh];
          if (op == OP_CLC) cf <= 1'b0;
          if (op == OP_CMP) begin
            cf <= $signed(ra_v) < $signed(rb_v);
            sf <= $signed(ra_v) < $signed(rb_v);
            zf <= ra_v == rb_v;
          end
          pc     <= pc_nx;
          icount <= icount + 32'd1;
        end
      end
      if (cmd.load_wb && rb != 3'd0) rf[rb] <= mem_q;
      // Swap uses register values after the dest write. Going through the
      // zero temp, a swap that names register zero changes nothing.
      if (cmd.swap && ra != 3'd0 && rb != 3'd0) begin
        rf[rb] <= rf[ra];
        rf[ra] <= rf[rb];
      end
    end
  end

  always_comb begin
    case (iw.kind)
      KIND_READ: rv = in_ok ? mem_q : 32'd0;
      KIND_REG:  rv = rf[iw.reg_index];
      default:   rv = '0;
    endcase
  end

  assign res.status          = mst;
  assign res.read_value      = rv;
  assign res.program_counter = pc;
  assign res.carry_flag      = cf;
  assign res.sign_flag       = sf;
  assign res.zero_flag       = zf;
  assign res.executed_count  = icount;

endmodule

### sv/extended_lc_cpu_core.sv
// ----------------------------------------------------------------------------
// extended_lc_cpu_core
// Eight-register word machine with debug access to memory and registers.
//
// Usage: one word on the input channel (valid/ready) gives exactly one word
// on the output channel. A memory write or register read goes straight to
// the output register; a memory read first reads the word, an instruction
// passes fetch, decode, execute and output, and a load write-back or a
// swap step follows execute when needed. An execute on a stopped machine or
// at a bad pc goes from fetch straight to output. With out_ready high the
// next input word is taken in the cycle the result leaves.
// After reset a clearing pass writes zero to every memory word, one word a
// cycle, and input ready stays low until it is done. The output holds in
// its register while out_ready is low; the next input word is not taken
// until that word leaves.
// ----------------------------------------------------------------------------
module extended_lc_cpu_core
  import elc_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  cmd_t      cmd;
  sts_t      sts;
  out_word_t res;

  elc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_kind(kind_t'(in_data.kind)), .in_ready,
    .out_valid, .out_ready, .sts, .cmd
  );

  elc_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk, .rst, .in_word(in_data), .cmd, .sts, .res
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= res;
  end

  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !in_ready)
    else $error("took two words back to back");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> out_valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

endmodule

### test/extended_lc_cpu_core_tb.sv
// ----------------------------------------------------------------------------
// extended_lc_cpu_core_tb
// Drives debug accesses and short random programs into the word machine and
// checks every output word against a cycle-free model of the instruction set.
// ----------------------------------------------------------------------------
module extended_lc_cpu_core_tb;
  import elc_pkg::*;

  localparam int MEM_WORDS   = 65536;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  extended_lc_cpu_core #(.MEM_WORDS(MEM_WORDS)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Machine state as predicted.
  logic [31:0] mem_img [MEM_WORDS];
  logic [31:0] regs [8];
  logic [31:0] pc;
  logic        cf, sf, zf;
  mstat_t      mstat;
  logic [31:0] icount;

  out_word_t   pending_words [$];
  int          errors = 0;
  int          words_seen = 0;
  int          execs_sent = 0;
  int          cycles = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          sent = 0;

  function automatic logic signed [63:0] sx(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic void swap_regs(inout logic [31:0] r [8], input int a, input int b);
    r[0] = r[b];
    r[b] = r[a];
    r[a] = r[0];
    r[0] = '0;
  endfunction

  function automatic void step_machine();
    logic [31:0] r [8];
    logic [31:0] w, nxt;
    logic [9:0]  op;
    int          ra, rb, rd;
    logic signed [63:0] off, ea, n;
    int          sh;
    if (mstat != ST_RUN) return;
    if (sx(pc) < 0 || sx(pc) >= MEM_WORDS) begin
      mstat = ST_PCERR;
      return;
    end
    w   = mem_img[pc[15:0]];
    op  = w[31:22];
    ra  = w[21:19];
    rb  = w[18:16];
    rd  = w[2:0];
    off = {{48{w[15]}}, w[15:0]};
    nxt = pc + 1;
    r   = regs;
    case (op)
      OP_ADD:  r[rd] = r[ra] + r[rb];
      OP_NAND: r[rd] = ~(r[ra] & r[rb]);
      OP_LW, OP_SW: begin
        ea = sx(r[ra]) + off;
        if (ea < 0 || ea >= MEM_WORDS) begin
          mstat = ST_ADDRERR;
          return;
        end
        if (op == OP_LW) r[rb] = mem_img[ea[15:0]];
        else mem_img[ea[15:0]] = r[rb];
      end
      OP_BEQ:  if (r[ra] == r[rb]) nxt = nxt + off[31:0];
      OP_JALR: begin
        r[rb] = nxt;
        nxt = (ra != 0) ? r[ra] : 32'd0;
      end
      OP_HALT: mstat = ST_HALT;
      OP_MUL:  r[rd] = r[ra] * r[rb];
      OP_XADD: begin
        r[rd] = r[ra] + r[rb];
        swap_regs(r, ra, rb);
      end
      OP_SUB:  r[rd] = r[ra] - r[rb];
      OP_XIMUL: begin
        r[rd] = r[ra] * r[rb];
        swap_regs(r, ra, rb);
      end
      OP_XOR:  r[rd] = r[ra] ^ r[rb];
      OP_SHL:  r[rd] = (r[rb] >= 32) ? 32'd0 : (r[ra] << r[rb][4:0]);
      OP_SLT:  r[rd] = (sx(r[ra]) < sx(r[rb])) ? 32'd1 : 32'd0;
      OP_BLO:  if (r[ra] < r[rb]) nxt = nxt + off[31:0];
      OP_BGT:  if (sx(r[ra]) > sx(r[rb])) nxt = nxt + off[31:0];
      OP_BT: begin
        n  = sx(r[rb]);
        sh = (n <= 0) ? 0 : ((n >= 31) ? 31 : int'(n));
        cf = r[ra][sh];
      end
      OP_CMP: begin
        cf = sx(r[ra]) < sx(r[rb]);
        sf = sx(r[ra]) < sx(r[rb]);
        zf = r[ra] == r[rb];
      end
      OP_CLC:  cf = 1'b0;
      default: begin
        mstat = ST_ILLEGAL;
        return;
      end
    endcase
    r[0]   = '0;
    regs   = r;
    pc     = nxt;
    icount = icount + 1;
  endfunction

  function automatic out_word_t predict_word(in_word_t it);
    out_word_t o;
    logic [31:0] rv;
    rv = '0;
    case (kind_t'(it.kind))
      KIND_WRITE: mem_img[it.address] = it.data;
      KIND_READ:  rv = mem_img[it.address];
      KIND_REG:   rv = regs[it.reg_index];
      default:    step_machine();
    endcase
    o.status          = mstat;
    o.read_value      = rv;
    o.program_counter = pc;
    o.carry_flag      = cf;
    o.sign_flag       = sf;
    o.zero_flag       = zf;
    o.executed_count  = icount;
    return o;
  endfunction

  task automatic machine_reset();
    foreach (mem_img[i]) mem_img[i] = '0;
    foreach (regs[i]) regs[i] = '0;
    pc = '0;
    cf = 1'b0;
    sf = 1'b0;
    zf = 1'b0;
    mstat = ST_RUN;
    icount = '0;
  endtask

  function automatic logic [31:0] instr(logic [9:0] op, int ra, int rb, int rd,
                                        logic [15:0] off);
    logic [31:0] w;
    w = {op, ra[2:0], rb[2:0], off};
    w[2:0] = (off == 0) ? rd[2:0] : off[2:0];
    return w;
  endfunction

  // Idling phase: 0 none, 1 sender, 2 receiver, 3 both.
  int phase = 0;

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      case (phase)
        2: out_ready <= !roll(51);
        3: out_ready <= !roll(9);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // Check against the oldest expectation.
  always @(posedge clk) begin
    out_word_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      words_seen <= words_seen + 1;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_data !== e) begin
          $display("%0t: expected st=%0d rv=%h pc=%h cf=%b sf=%b zf=%b n=%0d", $time,
                   e.status, e.read_value, e.program_counter, e.carry_flag,
                   e.sign_flag, e.zero_flag, e.executed_count);
          $display("%0t:   actual st=%0d rv=%h pc=%h cf=%b sf=%b zf=%b n=%0d", $time,
                   out_data.status, out_data.read_value, out_data.program_counter,
                   out_data.carry_flag, out_data.sign_flag, out_data.zero_flag,
                   out_data.executed_count);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Sends one word and, if a check value is given, compares the prediction.
  // Valid stays high after the word is taken; the next word replaces it, and an
  // idle gap or a drain drops it at a later falling edge.
  task automatic send(in_word_t it, bit has_ref = 0, out_word_t ref_word = '0);
    out_word_t p;
    if (phase == 1 || phase == 3)
      while (roll(phase == 1 ? 51 : 9)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_word(it);
    sent++;
    if (it.kind == KIND_EXEC) execs_sent++;
    if (has_ref && p !== ref_word) begin
      $display("%0t: expected %h, model gives %h", $time, ref_word, p);
      errors++;
    end
    pending_words.push_back(p);
    @(negedge clk);
  endtask

  function automatic in_word_t mk(kind_t k, logic [15:0] a, logic [31:0] d, logic [2:0] ri);
    in_word_t it;
    it.kind = k;
    it.address = a;
    it.data = d;
    it.reg_index = ri;
    return it;
  endfunction

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Random program of length len at word 0 with a small data area at 48..63.
  task automatic run_program(int len);
    logic [9:0] op;
    logic [15:0] off;
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99, 0);
      if (r < 3) op = 10'($urandom_range(1023, 19));
      else if (r < 6) op = OP_HALT;
      else begin
        op = 10'($urandom_range(18, 0));
        if (op == OP_HALT) op = OP_ADD;
      end
      case (op)
        OP_LW, OP_SW: off = roll(90) ? 16'($urandom_range(63, 48)) : 16'($urandom);
        OP_BEQ, OP_BLO, OP_BGT: off = roll(90) ? 16'($urandom_range(4, 0) - 2)
                                               : 16'($urandom);
        default: off = roll(50) ? 16'($urandom_range(7, 0)) : 16'($urandom);
      endcase
      send(mk(KIND_WRITE, 16'(i), {op, 3'($urandom), 3'($urandom), off}, '0));
    end
    for (int i = 48; i < 64; i++)
      if (roll(50)) send(mk(KIND_WRITE, 16'(i), $urandom, '0));
    for (int i = 0; i < len + 4; i++) send(mk(KIND_EXEC, '0, $urandom, '0));
    for (int i = 0; i < 3; i++) send(mk(KIND_REG, '0, '0, 3'($urandom)));
  endtask

  typedef struct {
    in_word_t  it;
    bit        has_ref;
    out_word_t ref_word;
  } row_t;

  row_t stim_rows [$];

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    machine_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // After reset, extremes of the debug fields, then a small program.
    stim_rows = '{
      '{mk(KIND_REG, '0, '0, 3'd7), 1, '{ST_RUN, 0, 0, 0, 0, 0, 0}},
      '{mk(KIND_READ, 16'hFFFF, '0, '0), 1, '{ST_RUN, 0, 0, 0, 0, 0, 0}},
      '{mk(KIND_WRITE, 16'hFFFF, 32'hFFFFFFFF, 3'd7), 1, '{ST_RUN, 0, 0, 0, 0, 0, 0}},
      '{mk(KIND_READ, 16'hFFFF, '0, '0), 1, '{ST_RUN, -1, 0, 0, 0, 0, 0}},
      '{mk(KIND_WRITE, 16'd8, 32'h80000000, '0), 0, '0},
      '{mk(KIND_WRITE, 16'd1, instr(OP_LW, 0, 1, 0, 16'd8), '0), 0, '0},
      '{mk(KIND_WRITE, 16'd2, instr(OP_NAND, 0, 0, 2, 0), '0), 0, '0},
      '{mk(KIND_WRITE, 16'd3, instr(OP_SHL, 2, 2, 3, 0), '0), 0, '0},
      '{mk(KIND_WRITE, 16'd4, instr(OP_CMP, 2, 0, 0, 0), '0), 0, '0},
      '{mk(KIND_WRITE, 16'd5, instr(OP_BT, 2, 2, 0, 0), '0), 0, '0},
      '{mk(KIND_WRITE, 16'd6, instr(OP_XADD, 1, 2, 4, 0), '0), 0, '0},
      '{mk(KIND_WRITE, 16'd7, instr(OP_JALR, 0, 5, 0, 0), '0), 0, '0},
      '{mk(KIND_READ, 16'd8, '0, '0), 1, '{ST_RUN, 32'h80000000, 0, 0, 0, 0, 0}},
      // First executes a zero word: add r0 = r0 + r0.
      '{mk(KIND_EXEC, '0, '0, '0), 0, '0},
      '{mk(KIND_EXEC, '0, '0, '0), 0, '0},
      '{mk(KIND_EXEC, '0, '0, '0), 0, '0},
      '{mk(KIND_EXEC, '0, '0, '0), 0, '0},
      '{mk(KIND_EXEC, '0, '0, '0), 0, '0},
      '{mk(KIND_EXEC, '0, '0, '0), 0, '0},
      '{mk(KIND_EXEC, '0, '0, '0), 0, '0},
      '{mk(KIND_EXEC, '0, '0, '0), 0, '0},
      '{mk(KIND_REG, '0, '0, 3'd5), 0, '0},
      '{mk(KIND_REG, '0, '0, 3'd4), 0, '0}
    };
    foreach (stim_rows[i]) begin
      send(stim_rows[i].it, stim_rows[i].has_ref, stim_rows[i].ref_word);
    end

    // Random part: short programs while the machine runs with pc below 40,
    // debug traffic once it has stopped or got past that.
    while (sent < 950) begin
      phase = (sent / 120) % 4;
      wait_drain();
      // Restart needs a fresh block state, so programs run while the machine
      // still runs with pc below 40; once frozen, or past that, only debug noise follows.
      if (mstat == ST_RUN && pc < 40) begin
        run_program($urandom_range(12, 3));
      end else begin
        for (int i = 0; i < 10; i++)
          send(mk(kind_t'($urandom_range(3, 0)), 16'($urandom), $urandom, 3'($urandom)));
      end
    end
    wait_drain();
    repeat (50) @(negedge clk);
    $display("Covered %0d output words, %0d executes, final status %0d.",
             words_seen, execs_sent, mstat);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
sv/elc_pkg.sv
sv/elc_ctrl.sv
sv/elc_dp.sv
sv/extended_lc_cpu_core.sv
test/extended_lc_cpu_core_tb.sv
